// ===== sv/rgb2hsl_pkg.sv =====
package rgb2hsl_pkg;

    localparam int unsigned QBITS   = 9;
    localparam int unsigned RBITS   = 18;
    // ceil(2^20 / 102): reciprocal of the reduced lightness divisor
    localparam int unsigned LIGHT_SHIFT = 20;
    localparam logic [26:0] LIGHT_RECIP = 27'd10281;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [8:0] hue_degrees;
        logic [6:0] saturation_percent;
        logic [6:0] lightness_percent;
    } t_hsl_out;

    // one word moving down the divider row: two restoring divisions in step,
    // lightness rides along already finished
    typedef struct packed {
        logic             grey;
        logic [RBITS-1:0] rem_h;
        logic [RBITS-1:0] rem_s;
        logic [8:0]       d_h;
        logic [8:0]       d_s;
        logic [QBITS-1:0] q_h;
        logic [QBITS-1:0] q_s;
        logic [6:0]       q_l;
    } t_div_word;

endpackage

// ===== sv/rgb2hsl_div_cell.sv =====
module rgb2hsl_div_cell
    import rgb2hsl_pkg::*;
#(
    parameter int unsigned K = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_word i_word,
    output logic      o_ready,
    input  logic      i_ready_dn,
    output logic      o_valid,
    output t_div_word o_word
);

    logic      r_valid;
    t_div_word r_word;
    t_div_word n_word;
    logic [RBITS-1:0] sh_h;
    logic [RBITS-1:0] sh_s;

    assign o_ready = !r_valid || i_ready_dn;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    assign sh_h = RBITS'(i_word.d_h) << K;
    assign sh_s = RBITS'(i_word.d_s) << K;

    always_comb begin
        n_word = i_word;
        if (i_word.rem_h >= sh_h) begin
            n_word.rem_h  = i_word.rem_h - sh_h;
            n_word.q_h[K] = 1'b1;
        end
        if (i_word.rem_s >= sh_s) begin
            n_word.rem_s  = i_word.rem_s - sh_s;
            n_word.q_s[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== sv/rgb_to_hsl_converter_top.sv =====
// An accepted pixel reaches its result word through one front stage (finding
// max/min, the numerators and the lightness), then nine cells.
// Throughput: one pixel per cycle; each cell retires one quotient bit of the
// hue and saturation divisions, and a stall backs up cell by cell.
// Reset (synchronous, active low) empties every stage; no other state.
module rgb_to_hsl_converter_top
    import rgb2hsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_pix_in  i_pix,
    output logic     o_stall,
    output logic     o_valid,
    output t_hsl_out o_hsl,
    input  logic     i_stall
);

    logic [8:0]  mx_hi;
    logic [8:0]  mx_lo;
    logic [8:0]  chroma;
    logic [8:0]  sum;
    logic [8:0]  den;
    logic [18:0] num_h;
    logic [13:0] lig_num;
    logic [26:0] lig_prod;
    t_div_word   n_front;
    t_div_word   r_front;
    logic        r_front_valid;

    logic      v   [QBITS+1];
    t_div_word w   [QBITS+1];
    logic      rdy [QBITS+1];

    always_comb begin
        mx_hi = {1'b0, i_pix.red};
        mx_lo = {1'b0, i_pix.red};
        if (i_pix.green > mx_hi[7:0]) mx_hi = {1'b0, i_pix.green};
        if (i_pix.blue  > mx_hi[7:0]) mx_hi = {1'b0, i_pix.blue};
        if (i_pix.green < mx_lo[7:0]) mx_lo = {1'b0, i_pix.green};
        if (i_pix.blue  < mx_lo[7:0]) mx_lo = {1'b0, i_pix.blue};
        chroma = mx_hi - mx_lo;
        sum    = mx_hi + mx_lo;
        den    = (sum <= 9'd255) ? sum : (9'd510 - sum);
        // sector order: red, then green, then blue
        priority if (mx_hi[7:0] == i_pix.red) begin
            if (i_pix.green >= i_pix.blue)
                num_h = 19'd60 * 19'(i_pix.green - i_pix.blue);
            else
                num_h = 19'd360 * 19'(chroma) - 19'd60 * 19'(i_pix.blue - i_pix.green);
        end else if (mx_hi[7:0] == i_pix.green) begin
            num_h = 19'd120 * 19'(chroma) + 19'd60 * 19'(i_pix.blue)
                  - 19'd60 * 19'(i_pix.red);
        end else begin
            num_h = 19'd240 * 19'(chroma) + 19'd60 * 19'(i_pix.red)
                  - 19'd60 * 19'(i_pix.green);
        end
        // (200 * sum + 510) / 1020 reduces to (20 * sum + 51) / 102
        lig_num  = 14'd20 * 14'(sum) + 14'd51;
        lig_prod = 27'(lig_num) * LIGHT_RECIP;
        // round half up: (2n + d) / 2d
        n_front.grey  = (chroma == 9'd0);
        n_front.rem_h = RBITS'({num_h, 1'b0} + 20'(chroma));
        n_front.rem_s = RBITS'(18'd200 * 18'(chroma) + 18'(den));
        n_front.d_h   = {chroma[7:0], 1'b0};
        n_front.d_s   = {den[7:0], 1'b0};
        n_front.q_h   = '0;
        n_front.q_s   = '0;
        n_front.q_l   = lig_prod[LIGHT_SHIFT +: 7];
    end

    assign o_stall = r_front_valid && !rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (!o_stall) begin
            r_front_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_front <= n_front;
        end
    end

    assign v[0] = r_front_valid;
    assign w[0] = r_front;
    assign rdy[QBITS] = !i_stall;

    // cell 0 resolves the top quotient bit
    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        rgb2hsl_div_cell #(.K(QBITS - 1 - g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (v[g]),
            .i_word     (w[g]),
            .o_ready    (rdy[g]),
            .i_ready_dn (rdy[g+1]),
            .o_valid    (v[g+1]),
            .o_word     (w[g+1])
        );
    end

    assign o_valid = v[QBITS];
    assign o_hsl.hue_degrees        = w[QBITS].grey ? 9'd0 : w[QBITS].q_h;
    assign o_hsl.saturation_percent = w[QBITS].grey ? 7'd0 : w[QBITS].q_s[6:0];
    assign o_hsl.lightness_percent  = w[QBITS].q_l;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hsl.hue_degrees <= 9'd360)
        else $error("hue out of range");
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hsl.saturation_percent <= 7'd100)
        else $error("saturation out of range");
    a_light_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hsl.lightness_percent <= 7'd100)
        else $error("lightness out of range");
    a_grey_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !w[QBITS].grey) |-> w[QBITS].q_s <= 9'd100)
        else $error("saturation quotient overflow");

endmodule
